[src/dsl_pkg.sv]
`timescale 1ns / 1ps

package dsl_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 16;
    localparam int COUNT_W      = 5;
    localparam int OP_W         = 2;
    localparam int CAPACITY_DEF = 16;

    // operation codes carried on s_tuser
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic            fire;
        logic [OP_W-1:0] op;
        logic            found;
        logic            full;
    } dsl_ctrl_t;

endpackage

[src/dsl_cell.sv]
`timescale 1ns / 1ps

module dsl_cell
    import dsl_pkg::*;
(
    input  logic                     aclk,
    input  dsl_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     valid,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic                     left_ins,
    input  logic signed [DATA_W-1:0] right_entry,
    output logic signed [DATA_W-1:0] entry,
    output logic                     ins,
    output logic                     eq
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     le;

    assign le    = entry_reg <= value;
    // an empty cell counts as a place where the new value may land
    assign ins   = !valid || le;
    assign eq    = valid && (entry_reg == value);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.fire) begin
            case (ctrl.op)
                OP_INSERT: begin
                    if (!ctrl.full && ins) begin
                        entry_next = left_ins ? left_entry : value;
                    end
                end
                OP_REMOVE: begin
                    // equal entries are contiguous, so every cell from the
                    // first match on moves one place toward the head
                    if (ctrl.found && valid && le) begin
                        entry_next = right_entry;
                    end
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[src/descending_sorted_list.sv]
`timescale 1ns / 1ps

// descending sorted list: keeps up to CAPACITY signed 32-bit values, largest first
// input channel s_*: s_tuser holds the operation (insert, remove, get, clear),
//   s_tdata holds the value and the 1-based position for get
// result channel m_*: one result per request with ok, read_value, count and
//   an empty flag; read_value is zero except for a successful get
// every cell compares its entry with the request in parallel and takes the
//   value or its neighbor's entry, so all cells update together
// the result is registered and is on m_* in the cycle after the request is taken
// throughput: one request per cycle while the receiver keeps m_tready high;
//   the result register decides whether the next request can enter
// reset clears the count and the result valid; stored entries are not cleared
//   and are never read before being written
// when the receiver stalls the result holds and s_tready drops until it is taken

module descending_sorted_list
    import dsl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], position[47:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], read_value[32:1], count[37:33], empty_res[38]
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [OP_W-1:0]          op;
    logic                     fire;

    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;
    logic [39:0]       m_tdata_next;

    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]      ins_w;
    logic [CAPACITY-1:0]      eq_w;
    logic [CAPACITY-1:0]      valid_w;

    dsl_ctrl_t ctrl;

    logic              full;
    logic              found;
    logic              pos_ok;
    logic [POS_W-1:0]  pos_m1;
    logic              ok;
    logic signed [DATA_W-1:0] rd;
    logic [31:0]       cnt_ext;

    assign value    = s_tdata[31:0];
    assign position = s_tdata[47:32];
    assign op       = s_tuser;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign full  = occ_reg == CNT_W'(CAPACITY);
    assign found = |eq_w;

    assign ctrl.fire  = fire;
    assign ctrl.op    = op;
    assign ctrl.found = found;
    assign ctrl.full  = full;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [DATA_W-1:0] left_entry;
            logic                     left_ins;
            logic signed [DATA_W-1:0] right_entry;

            assign valid_w[i] = CNT_W'(i) < occ_reg;

            if (i == 0) begin : g_head
                assign left_entry = '0;
                assign left_ins   = 1'b0;
            end else begin : g_body
                assign left_entry = entry_w[i-1];
                assign left_ins   = ins_w[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_mid
                assign right_entry = entry_w[i+1];
            end

            dsl_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .value       (value),
                .valid       (valid_w[i]),
                .left_entry  (left_entry),
                .left_ins    (left_ins),
                .right_entry (right_entry),
                .entry       (entry_w[i]),
                .ins         (ins_w[i]),
                .eq          (eq_w[i])
            );
        end
    endgenerate

    assign pos_ok = (position != '0) && (position <= POS_W'(occ_reg));
    assign pos_m1 = position - POS_W'(1);

    always_comb begin
        occ_next = occ_reg;
        ok       = 1'b0;
        rd       = '0;
        unique case (op)
            OP_INSERT: begin
                ok = !full;
                if (!full) begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                ok = found;
                if (found) begin
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            OP_GET: begin
                ok = pos_ok;
                if (pos_ok) begin
                    rd = entry_w[pos_m1[IDX_W-1:0]];
                end
            end
            OP_CLEAR: begin
                ok       = 1'b1;
                occ_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign cnt_ext      = 32'(occ_next);
    assign m_tdata_next = {1'b0, (occ_next == '0), cnt_ext[COUNT_W-1:0], rd, ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                occ_reg      <= occ_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/descending_sorted_list_test.sv]
`timescale 1ns / 1ps

module descending_sorted_list_test;
    import dsl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_REQS = 1450;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic                     drain;    // hold off until every result is back
    } list_req_t;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic                     empty_res;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // value[31:0], position[47:32]
    logic [1:0]  s_tuser  = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // ok[0], read_value[32:1], count[37:33], empty_res[38]

    descending_sorted_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    list_req_t    req_backlog[$];
    list_req_t    in_flight;
    list_result_t want_results[$];

    // shadow copy of the list, largest value first
    logic signed [DATA_W-1:0] shadow_list[CAPACITY_DEF];
    int shadow_len = 0;

    int errors       = 0;
    int checked      = 0;
    int cycles       = 0;
    int op_seen[4]   = '{0, 0, 0, 0};
    int full_rejects = 0;
    int failed_ops   = 0;
    int peak_len     = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    logic signed [DATA_W-1:0] recent[$];

    // alternate phases so both sides get stretches with no idling
    wire tx_quiet = ((cycles / 1000) % 4) inside {1, 3};
    wire rx_quiet = ((cycles / 1000) % 4) inside {2, 3};

    function automatic list_result_t list_apply(list_req_t rq);
        list_result_t r;
        int slot;
        int hit;
        r = '{default: '0};
        slot = 0;
        hit = -1;
        case (rq.op)
            OP_INSERT: begin
                if (shadow_len < CAPACITY_DEF) begin
                    slot = shadow_len;
                    for (int i = 0; i < shadow_len; i++) begin
                        if (shadow_list[i] <= rq.value) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = shadow_len; i > slot; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[slot] = rq.value;
                    shadow_len++;
                    r.ok = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow_list[i] == rq.value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (int'(rq.position) >= 1 && int'(rq.position) <= shadow_len) begin
                    r.read_value = shadow_list[rq.position-1];
                    r.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                shadow_len = 0;
                r.ok = 1'b1;
            end
        endcase
        r.count = shadow_len[COUNT_W-1:0];
        r.empty_res = (shadow_len == 0);
        op_seen[rq.op]++;
        if (!r.ok)
            failed_ops++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return int'($urandom_range(0, 16)) - 8;
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return -1;
                3: return 0;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, 65535));
        return POS_W'($urandom_range(0, CAPACITY_DEF + 2));
    endfunction

    task automatic add_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] position, logic drain);
        list_req_t rq;
        rq.op = op;
        rq.value = value;
        rq.position = position;
        rq.drain = drain;
        req_backlog.push_back(rq);
        if (op == OP_INSERT) begin
            recent.push_back(value);
            if (recent.size() > 24)
                void'(recent.pop_front());
        end
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready)
                want_results.push_back(list_apply(in_flight));
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (req_backlog.size() != 0 &&
                             !(req_backlog[0].drain && want_results.size() != 0)) begin
                    in_flight <= req_backlog[0];
                    s_tdata   <= {req_backlog[0].position, req_backlog[0].value};
                    s_tuser   <= req_backlog[0].op;
                    s_tvalid  <= 1'b1;
                    void'(req_backlog.pop_front());
                    gap_left  <= tx_quiet ? 0 : idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (want_results.size() == 0) begin
                    $error("result %0h arrived with none expected", m_tdata);
                    errors++;
                end else begin
                    want = want_results.pop_front();
                    check_field("ok", DATA_W'(want.ok), DATA_W'(m_tdata[0]));
                    check_field("read_value", want.read_value, m_tdata[32:1]);
                    check_field("count", DATA_W'(want.count), DATA_W'(m_tdata[37:33]));
                    check_field("empty_res", DATA_W'(want.empty_res), DATA_W'(m_tdata[38]));
                    checked++;
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= rx_quiet ? 0 : idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, want_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int made;
        int ins_pct;
        int run_len;
        int r;
        logic signed [DATA_W-1:0] v;

        // empty list corner cases
        add_request(OP_GET, 0, 1, 1'b0);
        add_request(OP_REMOVE, 5, 0, 1'b0);
        add_request(OP_CLEAR, 0, 0, 1'b0);
        // extremes and a duplicate, which goes ahead of its equal
        add_request(OP_INSERT, 32'sh7fff_ffff, 0, 1'b0);
        add_request(OP_INSERT, 32'sh8000_0000, 0, 1'b0);
        add_request(OP_INSERT, 0, 0, 1'b0);
        add_request(OP_INSERT, 0, 0, 1'b0);
        add_request(OP_INSERT, -1, 0, 1'b0);
        add_request(OP_GET, 0, 1, 1'b0);
        add_request(OP_GET, 0, 5, 1'b0);
        add_request(OP_GET, 0, 6, 1'b0);
        add_request(OP_GET, 0, 0, 1'b0);
        add_request(OP_REMOVE, 0, 0, 1'b0);
        add_request(OP_REMOVE, 77, 0, 1'b0);
        // fill to capacity, then one insert too many
        for (int i = 0; i < 12; i++)
            add_request(OP_INSERT, (i % 3) * 1000 - 1000, 0, 1'b0);
        add_request(OP_INSERT, 3, 0, 1'b0);
        add_request(OP_GET, 0, 16, 1'b0);
        add_request(OP_GET, 0, 16'hffff, 1'b0);
        add_request(OP_CLEAR, 0, 0, 1'b1);

        // random runs with varying insert pressure so the list fills and drains
        made = 0;
        while (made < RANDOM_REQS) begin
            case ($urandom_range(0, 3))
                0: ins_pct = 25;
                1: ins_pct = 50;
                2: ins_pct = 75;
                default: ins_pct = 92;
            endcase
            run_len = $urandom_range(20, 80);
            for (int i = 0; i < run_len; i++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct) begin
                    add_request(OP_INSERT, pick_value(), pick_position(),
                                $urandom_range(0, 99) == 0);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        if (recent.size() != 0 && $urandom_range(0, 99) < 70)
                            v = recent[$urandom_range(0, recent.size() - 1)];
                        else
                            v = pick_value();
                        add_request(OP_REMOVE, v, pick_position(), 1'b0);
                    end else if (r < 97) begin
                        add_request(OP_GET, pick_value(), pick_position(), 1'b0);
                    end else begin
                        add_request(OP_CLEAR, pick_value(), pick_position(), 1'b0);
                    end
                end
                made++;
            end
            if ($urandom_range(0, 9) < 4) begin
                add_request(OP_CLEAR, pick_value(), pick_position(),
                            $urandom_range(0, 9) < 3);
                made++;
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_tvalid || want_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d requests: %0d insert, %0d remove, %0d get, %0d clear; %0d results checked",
                 op_seen[OP_INSERT] + op_seen[OP_REMOVE] + op_seen[OP_GET] + op_seen[OP_CLEAR],
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_GET], op_seen[OP_CLEAR],
                 checked);
        $display("%0d failed operations, %0d inserts refused on a full list, peak length %0d",
                 failed_ops, full_rejects, peak_len);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[descending_sorted_list.f]
src/dsl_pkg.sv
src/dsl_cell.sv
src/descending_sorted_list.sv
tb/descending_sorted_list_test.sv
